// ===== rtl/pfrc_pkg.sv =====
// ============================================================================
// PCM format and rate converter package
// Shared widths, register indexes and the queue entry type.
// ============================================================================
package pfrc_pkg;

    // Data widths.
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;

    // Repeat count of one frame: 0 to MAX_REPEAT results.
    localparam int MAX_REPEAT = 4;
    localparam int CNT_W      = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_STEP_W      = DEF_FRAC_BITS + 3;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP   = 2'd2;

    // One converted frame and the number of times it is emitted.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CNT_W-1:0]           count;
    } t_entry;

endpackage

// ===== rtl/pfrc_if.sv =====
// ============================================================================
// PCM format and rate converter channels
// Valid/ready channels for input bytes, output samples and register writes.
// ============================================================================

// Input byte channel.
interface pfrc_byte_if import pfrc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// Output sample channel.
interface pfrc_sample_if import pfrc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// Configuration write channel.
interface pfrc_cfg_if import pfrc_pkg::*; #(parameter int DATA_W = DEF_STEP_W);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pfrc_front.sv =====
// ============================================================================
// PCM format and rate converter front end
// Holds the configuration, assembles frames from bytes, forms the mono sample
// and advances the phase accumulator to find the repeat count of each frame.
// ============================================================================
module pfrc_front import pfrc_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pfrc_byte_if.sink       i_byte,
    pfrc_cfg_if.sink        i_cfg,
    output logic            o_push_valid,
    output t_entry          o_push_entry,
    input  logic            i_push_ready
);

    localparam int StepW  = FRAC_BITS + 3;
    localparam int PhaseW = FRAC_BITS + 1;
    localparam logic [StepW-1:0] OneQ    = StepW'(1) << FRAC_BITS;
    localparam logic [StepW-1:0] HalfQ   = StepW'(1) << (FRAC_BITS - 1);
    localparam logic [StepW-1:0] MaxStep = StepW'(MAX_REPEAT) << FRAC_BITS;

    logic              r_sixteen_bit;
    logic              r_stereo;
    logic [StepW-1:0]  r_rate_step;
    logic [1:0]        r_byte_index;
    logic [23:0]       r_held_bytes;
    logic [PhaseW-1:0] r_phase;

    logic              accept;
    logic              cfg_wr;
    logic [1:0]        size_m1;
    logic              frame_done;
    logic [31:0]       frame;
    logic signed [16:0] sum16;
    logic [8:0]        sum8;
    logic [7:0]        lev8;
    logic [SAMPLE_W-1:0] sample;
    logic [StepW-1:0]  eff_step;
    logic [StepW-1:0]  phase_sum;
    logic [CNT_W-1:0]  repeat_cnt;
    logic [StepW-1:0]  wr_step;
    logic [StepW-1:0]  wr_eff;
    logic [PhaseW-1:0] wr_phase;

    // Handshakes: bytes wait on room in the queue and hold off while a
    // register write is offered, so a byte and a write never share a cycle.
    assign i_byte.ready = i_push_ready & ~i_cfg.valid;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid & i_byte.ready;
    assign cfg_wr       = i_cfg.valid & i_cfg.ready;

    // Frame length minus one: 3 for 16-bit stereo, 1 for 16-bit or stereo, else 0.
    assign size_m1    = {r_sixteen_bit & r_stereo, r_sixteen_bit | r_stereo};
    assign frame_done = (r_byte_index >= size_m1);

    // Place the new byte at its position in the frame.
    assign frame = {8'h00, r_held_bytes}
                 | (32'(i_byte.data_byte) << {r_byte_index, 3'b000});

    // Mono sample: floor average of sign-extended or offset channels.
    assign sum16 = {frame[15], frame[15:0]} + {frame[31], frame[31:16]};
    assign sum8  = {1'b0, frame[7:0]} + {1'b0, frame[15:8]};
    assign lev8  = r_stereo ? sum8[8:1] : frame[7:0];

    always_comb begin
        if (r_sixteen_bit) begin
            sample = r_stereo ? sum16[16:1] : frame[15:0];
        end else begin
            sample = {~lev8[7], lev8[6:0], 8'h00};
        end
    end

    // Phase step, limited to four; the integer part of the sum is the count.
    assign eff_step   = (r_rate_step > MaxStep) ? MaxStep : r_rate_step;
    assign phase_sum  = StepW'(r_phase) + eff_step;
    assign repeat_cnt = phase_sum[StepW-1:FRAC_BITS];

    // Phase reload for a newly written step.
    assign wr_step  = StepW'(i_cfg.data);
    assign wr_eff   = (wr_step > MaxStep) ? MaxStep : wr_step;
    assign wr_phase = (wr_eff <= OneQ) ? PhaseW'(OneQ - wr_eff) : PhaseW'(HalfQ);

    // Hand a finished frame to the queue when it is emitted at least once.
    assign o_push_valid        = accept & frame_done & (repeat_cnt != '0);
    assign o_push_entry.sample = sample;
    assign o_push_entry.count  = repeat_cnt;

    // Frame assembly, phase and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sixteen_bit <= 1'b1;
            r_stereo      <= 1'b0;
            r_rate_step   <= OneQ;
            r_byte_index  <= 2'd0;
            r_held_bytes  <= 24'h000000;
            r_phase       <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_SIXTEEN_BIT: begin
                    r_sixteen_bit <= i_cfg.data[0];
                    r_byte_index  <= 2'd0;
                    r_held_bytes  <= 24'h000000;
                end
                CFG_STEREO: begin
                    r_stereo     <= i_cfg.data[0];
                    r_byte_index <= 2'd0;
                    r_held_bytes <= 24'h000000;
                end
                CFG_RATE_STEP: begin
                    r_rate_step <= wr_step;
                    r_phase     <= wr_phase;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (frame_done) begin
                r_byte_index <= 2'd0;
                r_held_bytes <= 24'h000000;
                r_phase      <= {1'b0, phase_sum[FRAC_BITS-1:0]};
            end else begin
                r_byte_index <= r_byte_index + 2'd1;
                r_held_bytes <= frame[23:0];
            end
        end
    end

    // The phase never exceeds one, so a frame never needs more than four results.
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        StepW'(r_phase) <= OneQ)
        else $error("phase accumulator above one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && frame_done) |-> (repeat_cnt <= CNT_W'(MAX_REPEAT)))
        else $error("frame repeat count above four");

endmodule

// ===== rtl/pfrc_queue.sv =====
// ============================================================================
// PCM format and rate converter queue
// Short first-in first-out queue of converted frames between front and back.
// ============================================================================
module pfrc_queue import pfrc_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue fill level above depth");

endmodule

// ===== rtl/pfrc_back.sv =====
// ============================================================================
// PCM format and rate converter back end
// Takes frames from the queue and emits each sample as often as its count says.
// ============================================================================
module pfrc_back import pfrc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  t_entry        i_pop_entry,
    output logic          o_pop_ready,
    pfrc_sample_if.source o_sample
);

    logic                       r_cur_valid;
    logic signed [SAMPLE_W-1:0] r_cur_sample;
    logic [CNT_W-1:0]           r_cur_rem;

    logic out_fire;
    logic cur_done;

    // The output word comes straight from the current-frame registers.
    assign o_sample.valid  = r_cur_valid;
    assign o_sample.sample = r_cur_sample;
    assign o_sample.last   = (r_cur_rem == CNT_W'(1));

    // The current frame is finished when empty or when its last word goes out.
    assign out_fire    = r_cur_valid & o_sample.ready;
    assign cur_done    = ~r_cur_valid | (out_fire & (r_cur_rem == CNT_W'(1)));
    assign o_pop_ready = cur_done;

    // Remaining-count control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_cur_rem   <= '0;
        end else if (cur_done) begin
            r_cur_valid <= i_pop_valid;
            r_cur_rem   <= i_pop_valid ? i_pop_entry.count : '0;
        end else if (out_fire) begin
            r_cur_rem <= r_cur_rem - CNT_W'(1);
        end
    end

    // Sample register.
    always_ff @(posedge i_clk) begin
        if (cur_done && i_pop_valid) begin
            r_cur_sample <= i_pop_entry.sample;
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_cur_rem != '0 && r_cur_rem <= CNT_W'(MAX_REPEAT)))
        else $error("current frame has an invalid remaining count");

    a_repeat_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_sample.last) |=> (r_cur_valid && $stable(r_cur_sample)))
        else $error("repeated sample changed before the last word");

endmodule

// ===== rtl/pcm_format_rate_converter.sv =====
// ============================================================================
// PCM format and rate converter
// Little-endian PCM bytes in, nearest-neighbor rate-converted mono samples out.
// ============================================================================
// The block accepts one PCM byte per clock while its frame queue (four entries
// by default) has room and no register write is offered; the byte that completes
// a frame is converted and its repeat count (zero to four) is found in that same
// cycle. The output side then delivers one 16-bit sample per clock while the
// sink is ready. A completed frame passes through the queue register and then
// the current-frame register before its sample appears. Registers are written
// through the configuration channel, which is always ready; writes are meant
// for an idle block. Writing the format restarts frame assembly, writing the step
// reloads the phase. No clearing pass follows reset.
module pcm_format_rate_converter import pfrc_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfrc_byte_if.sink     i_byte,
    pfrc_cfg_if.sink      i_cfg,
    pfrc_sample_if.source o_sample
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    // Frame assembly and phase accumulator.
    pfrc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // Frame queue.
    pfrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    // Sample repeater and output register.
    pfrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_sample    (o_sample)
    );

endmodule
